>>> sv/mean_trajectory_distance_defines.svh
//------------------------------------------------------------------------------
// Mean trajectory distance: assertion macros
// Shared property forms for the checks at the top level.
//------------------------------------------------------------------------------
`ifndef MEAN_TRAJECTORY_DISTANCE_DEFINES_SVH
`define MEAN_TRAJECTORY_DISTANCE_DEFINES_SVH

// same-cycle implication
`define MTD_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTD_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mtd_pkg.sv
//------------------------------------------------------------------------------
// mtd_pkg
// Types, widths and controller encodings for the mean trajectory distance block.
//------------------------------------------------------------------------------
`default_nettype none

package mtd_pkg;

	localparam int COORD_W    = 24;
	localparam int MAG_W      = 24;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int RAD_W      = 50;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SUM_W      = 34;
	localparam int MEAN_W     = 25;
	localparam int COUNT_W    = 9;
	localparam int MAX_STEPS  = 256;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int ITER_W     = 6;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic                      last_pair;
	} in_req_t;

	typedef struct packed {
		logic [MEAN_W-1:0]  mean_distance;
		logic [COUNT_W-1:0] pair_count;
		logic               overflow;
	} out_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_ROOT,
		ST_ACC,
		ST_DIVL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sqsum;
		logic root_step;
		logic acc;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/mean_trajectory_distance.sv
// Pair without the last mark: the next request is taken after the MUL and ADD
// squaring states, the 25-step bitwise square root and the ACC accumulate.
// Pair with the last mark: the 34-step restoring divide follows the accumulate;
// the output register frees the input side once loaded.
// Reset (arst_n low, asynchronous): sum, count, overflow flag and output valid clear.
//------------------------------------------------------------------------------
// mean_trajectory_distance
// Mean Euclidean distance over a trajectory pair, one point pair per request.
//------------------------------------------------------------------------------
`default_nettype none

`include "mean_trajectory_distance_defines.svh"

module mean_trajectory_distance (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  mtd_pkg::in_req_t   in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mtd_pkg::out_req_t  out_data
);
	import mtd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`MTD_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd), "datapath commands overlap")
	`MTD_ASSERT_NOW(a_idle_no_iter, clk, arst_n, in_ready, !(cmd.root_step || cmd.div_step), "iteration while ready")
	`MTD_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "ready right after accept")
	`MTD_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, out_valid, "loaded result not shown")

endmodule

`default_nettype wire

>>> sv/mtd_ctrl.sv
//------------------------------------------------------------------------------
// mtd_ctrl
// Sequencer: square, root iterations, accumulate, divide iterations, output.
//------------------------------------------------------------------------------
`default_nettype none

module mtd_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  mtd_pkg::sts_t     sts,
	output mtd_pkg::cmd_t     cmd
);
	import mtd_pkg::*;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic              iter_clr, iter_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			if (iter_clr) begin
				iter_q <= '0;
			end else if (iter_inc) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		iter_clr = 1'b0;
		iter_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.sqsum = 1'b1;
				iter_clr  = 1'b1;
				state_d   = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				iter_inc      = 1'b1;
				if (iter_q == ITER_W'(ROOT_STEPS - 1)) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_DIVL : ST_IDLE;
			end
			ST_DIVL: begin
				cmd.div_init = 1'b1;
				iter_clr     = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				iter_inc     = 1'b1;
				if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/mtd_datapath.sv
//------------------------------------------------------------------------------
// mtd_datapath
// Differences, squares, bitwise square root, running sum and restoring divide.
//------------------------------------------------------------------------------
`default_nettype none

module mtd_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mtd_pkg::in_req_t   in_data,
	input  mtd_pkg::cmd_t      cmd,
	output mtd_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mtd_pkg::out_req_t  out_data
);
	import mtd_pkg::*;

	logic [MAG_W-1:0]   ux_q, uy_q;
	logic               last_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q;
	logic [RAD_W-1:0]   rad_q;
	logic [ROOT_W-1:0]  root_q;
	logic [REM_W-1:0]   rem_q;
	logic [SUM_W-1:0]   quo_q;
	logic [COUNT_W-1:0] drem_q;
	out_req_t           out_q;

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] steps_q;
	logic               ovf_q;
	logic               out_valid_q;

	logic [COORD_W:0]   dx, dy, ndx, ndy;
	logic [MAG_W-1:0]   ux, uy;
	logic [SQ_W-1:0]    sqx, sqy;
	logic [REM_W-1:0]   rem_sh, trial, rem_sub;
	logic               rem_ge;
	logic [COUNT_W:0]   div_sh, div_sub;
	logic               div_ge;
	logic [SUM_W:0]     sum_add;
	logic               full;

	assign dx  = {in_data.a_x[COORD_W-1], in_data.a_x} - {in_data.b_x[COORD_W-1], in_data.b_x};
	assign dy  = {in_data.a_y[COORD_W-1], in_data.a_y} - {in_data.b_y[COORD_W-1], in_data.b_y};
	assign ndx = '0 - dx;
	assign ndy = '0 - dy;
	assign ux  = dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
	assign uy  = dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
	assign sqx = ux_q * ux_q;
	assign sqy = uy_q * uy_q;

	assign rem_sh  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_ge  = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	assign div_sh  = {drem_q, quo_q[SUM_W-1]};
	assign div_ge  = div_sh >= {1'b0, steps_q};
	assign div_sub = div_sh - {1'b0, steps_q};

	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(root_q);
	assign full    = steps_q == COUNT_W'(MAX_STEPS);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ux_q   <= ux;
			uy_q   <= uy;
			last_q <= in_data.last_pair;
		end
		if (cmd.mul) begin
			sqx_q <= sqx;
			sqy_q <= sqy;
		end
		if (cmd.sqsum) begin
			rad_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
			root_q <= '0;
			rem_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (rem_ge) begin
				rem_q  <= rem_sub;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			quo_q  <= sum_q;
			drem_q <= '0;
		end else if (cmd.div_step) begin
			if (div_ge) begin
				drem_q <= div_sub[COUNT_W-1:0];
				quo_q  <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				drem_q <= div_sh[COUNT_W-1:0];
				quo_q  <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_q.mean_distance <= (steps_q == '0) ? '0 : quo_q[MEAN_W-1:0];
			out_q.pair_count    <= steps_q;
			out_q.overflow      <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			steps_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				sum_q   <= '0;
				steps_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					sum_q   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
					steps_q <= steps_q + 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

`default_nettype wire

>>> tb/mtd_checker.sv
//------------------------------------------------------------------------------
// mtd_checker
// Watches both channels of the mean trajectory distance block. It keeps its own
// running sum, step count and overflow flag, predicts each mean from the
// accepted point pairs, and compares every returned request field by field.
//------------------------------------------------------------------------------
module mtd_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  mtd_pkg::in_req_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  mtd_pkg::out_req_t out_data,
	output int                mismatches,
	output int                awaited
);
	timeunit 1ns;
	timeprecision 1ps;
	import mtd_pkg::*;

	localparam longint unsigned SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

	logic [SUM_W-1:0]   dist_sum;
	logic [COUNT_W-1:0] steps_taken;
	logic               extra_seen;
	out_req_t           means_due[$];

	function automatic logic [MAG_W-1:0] axis_span(logic [COORD_W-1:0] p, logic [COORD_W-1:0] q);
		logic signed [COORD_W:0] diff;
		diff = {p[COORD_W-1], p} - {q[COORD_W-1], q};
		return diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 25; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	task automatic absorb_pair(in_req_t r);
		longint unsigned ux;
		longint unsigned uy;
		longint unsigned total;
		out_req_t        res;
		ux = axis_span(r.a_x, r.b_x);
		uy = axis_span(r.a_y, r.b_y);
		if (steps_taken < MAX_STEPS) begin
			total = 64'(dist_sum) + floor_root(ux * ux + uy * uy);
			dist_sum = (total > SUM_CEIL) ? SUM_W'(SUM_CEIL) : SUM_W'(total);
			steps_taken = steps_taken + 1'b1;
		end else begin
			extra_seen = 1'b1;
		end
		if (r.last_pair) begin
			res.mean_distance = (steps_taken == 0) ? '0 : MEAN_W'(dist_sum / steps_taken);
			res.pair_count = steps_taken;
			res.overflow = extra_seen;
			means_due.push_back(res);
			dist_sum = '0;
			steps_taken = '0;
			extra_seen = 1'b0;
		end
	endtask

	task automatic check_mean(out_req_t got);
		out_req_t want;
		if (means_due.size() == 0) begin
			$error("unexpected request: mean_distance %0d pair_count %0d overflow %0d",
				got.mean_distance, got.pair_count, got.overflow);
			mismatches++;
			return;
		end
		want = means_due.pop_front();
		if (got.mean_distance !== want.mean_distance) begin
			$error("mean_distance: expected %0d, actual %0d",
				want.mean_distance, got.mean_distance);
			mismatches++;
		end
		if (got.pair_count !== want.pair_count) begin
			$error("pair_count: expected %0d, actual %0d", want.pair_count, got.pair_count);
			mismatches++;
		end
		if (got.overflow !== want.overflow) begin
			$error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			dist_sum = '0;
			steps_taken = '0;
			extra_seen = 1'b0;
		end else begin
			if (in_valid && in_ready)
				absorb_pair(in_data);
			if (out_valid && out_ready)
				check_mean(out_data);
		end
		awaited = means_due.size();
	end

endmodule

>>> tb/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Drives point pairs into the mean trajectory distance block: a directed set
// of extreme and exact cases, then random trajectories of mixed length,
// including ones that reach and exceed the step limit. Both channels stall
// at random; a separate checker predicts and compares the means.
//------------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mtd_pkg::*;

	localparam int ITEM_GOAL    = 950;
	localparam int TRACK_GOAL   = 36;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] C_ONES = {COORD_W{1'b1}};
	localparam logic [COORD_W-1:0] C_ZERO = '0;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     out_ready = 1'b0;
	in_req_t  in_data = '0;
	logic     in_ready;
	logic     out_valid;
	out_req_t out_data;
	int       mismatches;
	int       awaited;
	int       idle_cycles = 0;
	int       pairs_sent = 0;
	int       tracks_sent = 0;

	always #5 clk = ~clk;

	mean_trajectory_distance DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	mtd_checker watcher (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mismatches(mismatches),
		.awaited   (awaited)
	);

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [COORD_W-1:0] corner_coord();
		case ($urandom_range(0, 4))
			0: return C_MAX;
			1: return C_MIN;
			2: return C_ONES;
			3: return C_ZERO;
			default: return 24'd1;
		endcase
	endfunction

	function automatic in_req_t random_pair(logic last);
		in_req_t            r;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		r.a_x = COORD_W'($urandom());
		r.a_y = COORD_W'($urandom());
		r.b_x = COORD_W'($urandom());
		r.b_y = COORD_W'($urandom());
		r.last_pair = last;
		dx = COORD_W'($urandom_range(0, 8192) - 4096);
		dy = COORD_W'($urandom_range(0, 8192) - 4096);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5, 6, 7: begin
				r.b_x = r.a_x + dx;
				r.b_y = r.a_y + dy;
			end
			8: begin
				r.a_x = corner_coord();
				r.a_y = corner_coord();
				r.b_x = corner_coord();
				r.b_y = corner_coord();
			end
			default: begin
				r.b_x = r.a_x;
				r.b_y = r.a_y;
			end
		endcase
		return r;
	endfunction

	task automatic send_pair(in_req_t r, bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
	endtask

	task automatic send_point(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
		logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by, logic last);
		in_req_t r;
		r.a_x = ax;
		r.a_y = ay;
		r.b_x = bx;
		r.b_y = by;
		r.last_pair = last;
		send_pair(r, 1'b0);
	endtask

	task automatic send_track(int len);
		bit rush;
		rush = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < len; k++)
			send_pair(random_pair(k == len - 1), rush);
		tracks_sent++;
	endtask

	initial begin
		int run;
		wait (arst_n);
		forever begin
			run = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (run - 1) @(negedge clk);
			run = pick_gap();
			repeat (run) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int long_lens[$];
		long_lens = '{256, 257, 258};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// largest spans, zero span, 3-4-5 and sub-LSB roots, rounding down
		send_point(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
		send_point(C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
		send_point(C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1);
		send_point(24'd768, 24'd1024, C_ZERO, C_ZERO, 1'b0);
		send_point(C_ZERO, C_ZERO, 24'd1, 24'd1, 1'b0);
		send_point(C_MAX, C_ZERO, C_MIN, C_ZERO, 1'b1);
		send_point(C_MAX, C_ZERO, C_MIN, C_ZERO, 1'b0);
		send_point(C_ZERO, C_MIN, C_ZERO, C_MAX, 1'b1);
		send_point(-24'sd5, 24'sd7, 24'sd9, -24'sd3, 1'b1);
		send_point(24'd1, C_ZERO, C_ZERO, C_ZERO, 1'b0);
		send_point(24'd2, C_ZERO, C_ZERO, C_ZERO, 1'b1);
		send_point(C_ONES, C_ONES, C_ZERO, C_ZERO, 1'b0);
		send_point(C_ZERO, 24'h555555, C_ZERO, 24'hAAAAAA, 1'b1);

		// long tracks hit the step limit exactly, by one on the last pair, and past it
		while (pairs_sent < ITEM_GOAL || tracks_sent < TRACK_GOAL || long_lens.size() != 0) begin
			if (long_lens.size() != 0 && ($urandom_range(0, 7) == 0 || pairs_sent >= ITEM_GOAL))
				send_track(long_lens.pop_front());
			else
				send_track(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 30));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
